[rtl/core/mdit_pkg.sv]
// Package for the multi-slot delay and interval timer.
// Holds the command codes, the reset due window, the transaction structs, the
// sequencer states and the memory control group. No dependencies.
`timescale 1ns / 1ps

package mdit_pkg;

	localparam logic [1:0] CMD_CHECK    = 2'd0;
	localparam logic [1:0] CMD_ONESHOT  = 2'd1;
	localparam logic [1:0] CMD_PERIODIC = 2'd2;
	localparam logic [1:0] CMD_CANCEL   = 2'd3;

	// Ten days in milliseconds.
	localparam logic [31:0] DUE_WINDOW_RST = 32'd864000000;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  slot;
		logic [31:0] duration;
		logic [31:0] now;
	} mdit_in_t;

	typedef struct packed {
		logic [3:0] fired_slot;
		logic       fired_periodic;
		logic       last;
	} mdit_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_FLUSH
	} mdit_state_t;

	typedef struct packed {
		logic rd_en;
		logic dl_we;
		logic pr_we;
	} mdit_mem_ctl_t;

endpackage

[rtl/core/mdit_slot_mem.sv]
// Deadline and period storage, one entry per timer slot.
// One write port per array, one shared registered read port. Uses mdit_pkg.
`timescale 1ns / 1ps

module mdit_slot_mem
	import mdit_pkg::*;
#(
	parameter int NUM_SLOTS = 16,
	localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic            clk,
	input  mdit_mem_ctl_t   ctl,
	input  logic [IdxW-1:0] waddr,
	input  logic [31:0]     dl_wdata,
	input  logic [31:0]     pr_wdata,
	input  logic [IdxW-1:0] raddr,
	output logic [31:0]     dl_rdata,
	output logic [31:0]     pr_rdata
);

	logic [31:0] dl_mem [NUM_SLOTS];
	logic [31:0] pr_mem [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (ctl.dl_we) begin
			dl_mem[waddr] <= dl_wdata;
		end
		if (ctl.pr_we) begin
			pr_mem[waddr] <= pr_wdata;
		end
	end

	// Hold read data between reads so an evaluation can wait on the output.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			dl_rdata <= dl_mem[raddr];
			pr_rdata <= pr_mem[raddr];
		end
	end

endmodule

[rtl/core/mdit_due_unit.sv]
// Shared timer arithmetic: wrapped lateness compare and deadline adder.
// Serves both arming and rescheduling. Uses mdit_pkg for house consistency.
`timescale 1ns / 1ps

module mdit_due_unit
	import mdit_pkg::*;
(
	input  logic [31:0] now,
	input  logic [31:0] deadline,
	input  logic [31:0] window,
	input  logic [31:0] addend,
	output logic        due,
	output logic [31:0] sum
);

	logic [31:0] late;

	// Lateness wraps modulo 2^32; anything beyond the window counts as future.
	assign late = now - deadline;
	assign due  = (late <= window);
	assign sum  = now + addend;

endmodule

[rtl/core/multi_slot_delay_interval_timer.sv]
// Top level of the multi-slot delay and interval timer.
// Depends on mdit_pkg, mdit_slot_mem and mdit_due_unit.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one command per transaction.
//     Arm one-shot, arm periodic and cancel complete in the accepting cycle;
//     in_ready stays high for the next transaction. They never give results.
//   A check walks the slots twice with one shared subtract/compare/add unit:
//     one pass for one-shot slots, one for periodic slots, ascending order.
//     A slot of the wrong kind or inactive is skipped; a candidate takes a
//     memory read, then an evaluation. in_ready is low while a check runs,
//     including any stall time. Candidates are read one at a time through
//     the slot memory's single read port.
//   out channel (out_valid/out_ready/out_data): one fired slot per
//     transaction; last marks the final one of a check. One result is held
//     back in a pending register so last is known when it is sent.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): due_window, always ready.
//     Write only while the block is idle.
//   Receiver stall: the scan waits on the current slot until the output
//     register frees; nothing is dropped.
//   Reset: all slots idle, due_window back to ten days, no result pending.
//   Deadline and period memories are not cleared; only active slots read them.
`timescale 1ns / 1ps

module multi_slot_delay_interval_timer
	import mdit_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  mdit_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output mdit_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IdxW-1:0] IDX_LAST = IdxW'(NUM_SLOTS - 1);

	mdit_state_t state_q, state_d;

	logic [IdxW-1:0]      idx_q;
	logic                 pass_q;       // 0: one-shot pass, 1: periodic pass
	logic [31:0]          now_q;
	logic [31:0]          window_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] periodic_q;

	logic                 pend_valid_q;
	logic [3:0]           pend_slot_q;
	logic                 pend_per_q;
	logic                 out_valid_q;
	mdit_out_t            out_q;

	mdit_mem_ctl_t        mem_ctl;
	logic [IdxW-1:0]      waddr;
	logic [31:0]          pr_wdata;
	logic [31:0]          rd_deadline;
	logic [31:0]          rd_period;

	logic [31:0]          now_op;
	logic [31:0]          add_op;
	logic                 due;
	logic [31:0]          sum;

	logic                 in_fire;
	logic                 out_free;
	logic                 slot_ok;
	logic [IdxW-1:0]      arm_idx;
	logic                 is_arm;
	logic                 is_cancel;
	logic                 is_check;
	logic                 cand;
	logic                 adv;
	logic                 load_pend;
	logic                 push;
	logic                 push_last;
	logic                 clear_active;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign slot_ok  = ({28'd0, in_data.slot} < 32'(NUM_SLOTS));
	assign arm_idx  = IdxW'(in_data.slot);

	assign is_check  = in_fire && (in_data.command == CMD_CHECK);
	assign is_cancel = in_fire && slot_ok && (in_data.command == CMD_CANCEL);
	assign is_arm    = in_fire && slot_ok &&
		((in_data.command == CMD_ONESHOT) || (in_data.command == CMD_PERIODIC));

	// Slot worth reading in the current pass.
	assign cand = active_q[idx_q] && (periodic_q[idx_q] == pass_q);

	// Share the arithmetic: arming uses the input time, the scan the latched one.
	assign now_op   = (state_q == ST_IDLE) ? in_data.now : now_q;
	assign add_op   = (state_q == ST_IDLE) ? in_data.duration : rd_period;
	assign pr_wdata = (in_data.command == CMD_PERIODIC) ? in_data.duration : 32'd0;
	assign waddr    = (state_q == ST_IDLE) ? arm_idx : idx_q;

	mdit_due_unit u_due (
		.now      (now_op),
		.deadline (rd_deadline),
		.window   (window_q),
		.addend   (add_op),
		.due      (due),
		.sum      (sum)
	);

	mdit_slot_mem #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.waddr    (waddr),
		.dl_wdata (sum),
		.pr_wdata (pr_wdata),
		.raddr    (idx_q),
		.dl_rdata (rd_deadline),
		.pr_rdata (rd_period)
	);

	// Sequencer: next state and per-cycle controls.
	always_comb begin
		state_d      = state_q;
		mem_ctl      = '0;
		adv          = 1'b0;
		load_pend    = 1'b0;
		push         = 1'b0;
		push_last    = 1'b0;
		clear_active = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (is_check) begin
					state_d = ST_READ;
				end else if (is_arm) begin
					mem_ctl.dl_we = 1'b1;
					mem_ctl.pr_we = 1'b1;
				end
			end
			ST_READ: begin
				if (cand) begin
					mem_ctl.rd_en = 1'b1;
					state_d       = ST_EVAL;
				end else begin
					adv = 1'b1;
				end
			end
			ST_EVAL: begin
				if (!due) begin
					adv     = 1'b1;
					state_d = ST_READ;
				end else if (!pend_valid_q || out_free) begin
					// Fire: send the held result onwards, hold this one.
					load_pend = 1'b1;
					push      = pend_valid_q;
					adv       = 1'b1;
					state_d   = ST_READ;
					if (pass_q) begin
						mem_ctl.dl_we = 1'b1;
					end else begin
						clear_active = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// Leaving the last slot of the periodic pass ends the walk.
		if (adv && (idx_q == IDX_LAST) && pass_q) begin
			state_d = ST_FLUSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan pointer and pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pass_q <= 1'b0;
		end else if (is_check) begin
			idx_q  <= '0;
			pass_q <= 1'b0;
		end else if (adv) begin
			if (idx_q == IDX_LAST) begin
				idx_q  <= '0;
				pass_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_check) begin
			now_q <= in_data.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= DUE_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	// Slot status bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			periodic_q <= '0;
		end else begin
			if (is_arm) begin
				active_q[arm_idx]   <= 1'b1;
				periodic_q[arm_idx] <= (in_data.command == CMD_PERIODIC);
			end
			if (is_cancel) begin
				active_q[arm_idx]   <= 1'b0;
				periodic_q[arm_idx] <= 1'b0;
			end
			if (clear_active) begin
				active_q[idx_q] <= 1'b0;
			end
		end
	end

	// Pending result, held back until the next one or the end of the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (load_pend) begin
			pend_valid_q <= 1'b1;
		end else if (push_last) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend) begin
			pend_slot_q <= 4'(idx_q);
			pend_per_q  <= pass_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push || push_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push || push_last) begin
			out_q.fired_slot     <= pend_slot_q;
			out_q.fired_periodic <= pend_per_q;
			out_q.last           <= push_last;
		end
	end

endmodule

[rtl/core/mdit_checker.sv]
// Port-level checker for the timer, with its bind to the top level.
// Depends on mdit_pkg and multi_slot_delay_interval_timer.
`timescale 1ns / 1ps

module mdit_checker
	import mdit_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input mdit_in_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input mdit_out_t out_data
);

	// A check makes the block busy in the next cycle.
	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.command == CMD_CHECK) |=> !in_ready)
		else $error("check transaction did not make the block busy");

	// Arm and cancel finish at once.
	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.command != CMD_CHECK) |=> in_ready)
		else $error("arm or cancel held the block busy");

	// When idle, any result still waiting is the final one of its check.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_ready |-> out_data.last)
		else $error("idle with a non-final result outstanding");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped under stall");

endmodule

bind multi_slot_delay_interval_timer mdit_checker u_mdit_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[tb/sv/tb_multi_slot_delay_interval_timer.sv]
// Self-checking testbench for multi_slot_delay_interval_timer: a directed run, then random
// arm, cancel and check traffic under several due windows, checked against a local predictor.
// Depends on mdit_pkg and the RTL of the timer.
`timescale 1ns / 1ps

module tb_multi_slot_delay_interval_timer;
	import mdit_pkg::*;

	localparam int SLOTS = 16;
	localparam int ITEMS_PER_PHASE = 92;
	// A check walks every slot twice; settle long enough for a silent one to finish.
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_SLOW
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	mdit_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	mdit_out_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	// Commands waiting for the driver, and fired slots still owed by the block.
	mdit_in_t  cmd_backlog[$];
	mdit_out_t owed_fires[$];

	// Predictor copy of the timer state and of the due window.
	logic        slot_on[SLOTS];
	logic        slot_rep[SLOTS];
	logic [31:0] slot_due[SLOTS];
	logic [31:0] slot_every[SLOTS];
	logic [31:0] window_q = DUE_WINDOW_RST;

	int          err_cnt = 0;
	int          fires_seen = 0;
	int          cfg_writes = 0;
	logic        in_fire = 1'b0;
	logic [31:0] ms_now = '0;

	// Driver burst state.
	int burst_left = 0;
	int gap_left = 0;

	// Receiver stall state.
	rx_mode_t rx_mode = RX_FREE;
	int       mode_left = 0;
	int       hold_left = 0;
	int       next_hold_at = 40;

	multi_slot_delay_interval_timer #(
		.NUM_SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Work out what one accepted command does to the slots and queue the slots it fires:
	// due one-shot slots first, then due periodic ones, each in ascending order.
	task automatic predict_fired_slots(input mdit_in_t c);
		mdit_out_t   hits[$];
		mdit_out_t   hit;
		logic [31:0] lateness;
		if (c.command == CMD_CHECK) begin
			for (int pass = 0; pass < 2; pass++) begin
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_on[s] && slot_rep[s] == (pass == 1)) begin
						lateness = c.now - slot_due[s];
						if (lateness <= window_q) begin
							hit.fired_slot = 4'(s);
							hit.fired_periodic = slot_rep[s];
							hit.last = 1'b0;
							hits.push_back(hit);
							if (slot_rep[s])
								slot_due[s] = c.now + slot_every[s];
							else
								slot_on[s] = 1'b0;
						end
					end
				end
			end
			if (hits.size() > 0)
				hits[hits.size() - 1].last = 1'b1;
			foreach (hits[k])
				owed_fires.push_back(hits[k]);
		end else if (c.command == CMD_CANCEL) begin
			slot_on[c.slot] = 1'b0;
			slot_rep[c.slot] = 1'b0;
		end else begin
			// Arming replaces kind, deadline and period, active or not.
			slot_on[c.slot] = 1'b1;
			slot_rep[c.slot] = (c.command == CMD_PERIODIC);
			slot_due[c.slot] = c.now + c.duration;
			slot_every[c.slot] = (c.command == CMD_PERIODIC) ? c.duration : 32'd0;
		end
	endtask

	// Monitor: sample every channel at the rising edge. Check the result side before
	// predicting, so a command taken on the same edge only adds later results.
	always @(posedge clk) begin
		mdit_out_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				fires_seen++;
				if (owed_fires.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected fire, slot %0d periodic %0b last %0b", $time,
						out_data.fired_slot, out_data.fired_periodic, out_data.last);
				end else begin
					want = owed_fires.pop_front();
					if (out_data.fired_slot !== want.fired_slot) begin
						err_cnt++;
						$display("%0t: fired_slot expected %0d actual %0d", $time,
							want.fired_slot, out_data.fired_slot);
					end
					if (out_data.fired_periodic !== want.fired_periodic) begin
						err_cnt++;
						$display("%0t: fired_periodic expected %0b actual %0b", $time,
							want.fired_periodic, out_data.fired_periodic);
					end
					if (out_data.last !== want.last) begin
						err_cnt++;
						$display("%0t: last expected %0b actual %0b", $time,
							want.last, out_data.last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				window_q = cfg_data;
				cfg_writes++;
			end
			if (in_valid && in_ready)
				predict_fired_slots(in_data);
		end
	end

	// Driver: hold the offered transaction until taken, then either idle out the gap or
	// offer the next command. Bursts and gaps are drawn afresh at the end of each burst.
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= cmd_backlog.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a long hold-off now and then, so the block backs up and drops in_ready
	// while the driver keeps offering; otherwise switch between stall patterns.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (fires_seen >= next_hold_at) begin
			hold_left = HOLD_OFF_CYCLES - 1;
			next_hold_at += 160;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic queue_cmd(input logic [1:0] cmd, input logic [3:0] slot,
		input logic [31:0] dur, input logic [31:0] now);
		mdit_in_t c;
		c.command = cmd;
		c.slot = slot;
		c.duration = dur;
		c.now = now;
		cmd_backlog.push_back(c);
	endtask

	// Mostly a plausible timeline: time moves forward in small steps, slots are armed
	// relative to it and checked at it. The rest is noise: odd times and random items.
	task automatic queue_timer_traffic(input int count);
		int pick;
		logic [31:0] dur;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
			if (pick < 30) begin
				ms_now += $urandom_range(0, 20);
				queue_cmd(CMD_CHECK, 4'($urandom), $urandom, ms_now);
			end else if (pick < 50) begin
				queue_cmd(CMD_ONESHOT, 4'($urandom), dur, ms_now);
			end else if (pick < 65) begin
				queue_cmd(CMD_PERIODIC, 4'($urandom), dur, ms_now);
			end else if (pick < 80) begin
				queue_cmd(CMD_CANCEL, 4'($urandom), $urandom, $urandom);
			end else if (pick < 90) begin
				queue_cmd(CMD_CHECK, 4'($urandom), $urandom, $urandom);
			end else begin
				queue_cmd(2'($urandom), 4'($urandom), $urandom, $urandom);
			end
		end
	endtask

	// Wait until every command is in and every fired slot is out, then let a silent
	// check finish its scan.
	task automatic wait_until_idle();
		while (cmd_backlog.size() > 0 || in_valid || owed_fires.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_due_window(input logic [31:0] value);
		int writes_so_far;
		writes_so_far = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		while (cfg_writes == writes_so_far) @(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] windows[5];
		foreach (slot_on[s]) begin
			slot_on[s] = 1'b0;
			slot_rep[s] = 1'b0;
			slot_due[s] = '0;
			slot_every[s] = '0;
		end
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed run under the reset window of ten days.
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, 32'd0);             // nothing armed, nothing fires
		queue_cmd(CMD_ONESHOT, 4'd0, 32'd0, 32'd100);         // zero delay: due at next check
		queue_cmd(CMD_ONESHOT, 4'd15, 32'd5, 32'd100);
		queue_cmd(CMD_PERIODIC, 4'd3, 32'd0, 32'd100);        // zero period fires every check
		queue_cmd(CMD_PERIODIC, 4'd7, 32'd10, 32'd100);
		queue_cmd(CMD_CHECK, 4'd9, 32'hFFFF_FFFF, 32'd100);   // slot and duration ignored
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, 32'd105);
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, 32'd110);
		queue_cmd(CMD_ONESHOT, 4'd5, 32'd50, 32'd110);
		queue_cmd(CMD_PERIODIC, 4'd5, 32'd20, 32'd110);       // re-arm changes the kind
		queue_cmd(CMD_CANCEL, 4'd5, 32'd0, 32'd0);
		queue_cmd(CMD_CANCEL, 4'd9, 32'd0, 32'd0);            // cancel of an idle slot
		queue_cmd(CMD_CANCEL, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(CMD_ONESHOT, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, 32'hFFFF_FFF0);     // deadline still ahead
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, 32'd5);             // due across the wrap of time
		queue_cmd(CMD_ONESHOT, 4'd1, 32'd0, 32'd0);
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, DUE_WINDOW_RST + 32'd120); // lateness on the edge
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, DUE_WINDOW_RST + 32'd1);   // one past the window
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, DUE_WINDOW_RST);
		queue_cmd(CMD_PERIODIC, 4'd2, 32'd0, 32'd0);
		queue_cmd(CMD_ONESHOT, 4'd12, 32'd0, 32'd0);
		queue_cmd(CMD_CHECK, 4'd0, 32'd0, 32'd0);             // one-shot 12 before periodic 2
		wait_until_idle();

		// Random phases, each under its own window; one starts just short of the wrap.
		windows[0] = 32'd0;
		windows[1] = 32'hFFFF_FFFF;
		windows[2] = 32'd25;
		windows[3] = $urandom;
		windows[4] = DUE_WINDOW_RST;
		foreach (windows[p]) begin
			write_due_window(windows[p]);
			if (p == 2)
				ms_now = 32'hFFFF_FF00;
			queue_timer_traffic(ITEMS_PER_PHASE);
			wait_until_idle();
		end

		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
